// ----- src/i2cfs_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cfs_pkg
// Types and constants of the I2C FIFO transfer sequencer.
// ----------------------------------------------------------------------------
package i2cfs_pkg;

  // Descriptor table depth, 1..64.
  localparam int unsigned MAX_MSGS  = 8;
  // Byte buffer depth, a power of two from 16 to 4096.
  localparam int unsigned BUF_DEPTH = 256;

  localparam int unsigned MSG_AW = (MAX_MSGS > 1) ? $clog2(MAX_MSGS) : 1;
  localparam int unsigned REM_W  = $clog2(MAX_MSGS + 1);
  localparam int unsigned BUF_AW = $clog2(BUF_DEPTH);
  // Widths that hold an offset sum or a byte address before wrapping.
  localparam int unsigned SUM_W  = (BUF_AW > 9) ? BUF_AW : 9;
  localparam int unsigned BA_W   = (BUF_AW > 8) ? BUF_AW : 8;
  localparam int unsigned SL_W   = (MSG_AW > 3) ? MSG_AW : 3;

  // Result bank depth: the most results one transaction can produce.
  localparam int unsigned RES_N  = 4;

  localparam logic [1:0] CMD_LD_DESC = 2'd0;
  localparam logic [1:0] CMD_LD_BYTE = 2'd1;
  localparam logic [1:0] CMD_START   = 2'd2;
  localparam logic [1:0] CMD_EVENT   = 2'd3;

  localparam logic [1:0] RK_WORD = 2'd0;
  localparam logic [1:0] RK_RX   = 2'd1;
  localparam logic [1:0] RK_DONE = 2'd2;

  localparam logic [9:0] ST_ERRORS  = 10'h0fc;
  localparam logic [9:0] ST_WR_FULL = 10'h001;
  localparam logic [9:0] ST_RD_FULL = 10'h002;

  localparam logic [9:0] WW_ADDR = 10'h100;
  localparam logic [9:0] WW_LAST = 10'h200;

  // Byte position code: address word still to be sent.
  localparam logic [8:0] POS_ADDR = 9'h1ff;

  localparam logic       DONE_OK  = 1'b0;
  localparam logic       DONE_ERR = 1'b1;

  typedef struct packed {
    logic [7:0] base;
    logic [7:0] len;
    logic       is_read;
    logic [6:0] addr;
  } desc_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] desc_slot;
    logic [6:0] target_addr;
    logic       is_read;
    logic [7:0] msg_length;
    logic [7:0] msg_base;
    logic [7:0] byte_addr;
    logic [7:0] byte_value;
    logic [3:0] msg_count;
    logic [9:0] status_word;
    logic [7:0] fifo_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] write_word;
    logic [7:0] rx_addr;
    logic [7:0] rx_value;
    logic       done_code;
    logic [7:0] flushed_bytes;
  } result_t;

endpackage

// ----- src/i2cfs_in_if.sv -----
// ----------------------------------------------------------------------------
// i2cfs_in_if
// Input channel of the sequencer: load, start and controller event items.
// ----------------------------------------------------------------------------
interface i2cfs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [2:0] desc_slot;
  logic [6:0] target_addr;
  logic       is_read;
  logic [7:0] msg_length;
  logic [7:0] msg_base;
  logic [7:0] byte_addr;
  logic [7:0] byte_value;
  logic [3:0] msg_count;
  logic [9:0] status_word;
  logic [7:0] fifo_byte;

  modport source (
    output valid, cmd, desc_slot, target_addr, is_read, msg_length, msg_base,
           byte_addr, byte_value, msg_count, status_word, fifo_byte,
    input  ready
  );

  modport sink (
    input  valid, cmd, desc_slot, target_addr, is_read, msg_length, msg_base,
           byte_addr, byte_value, msg_count, status_word, fifo_byte,
    output ready
  );
endinterface

// ----- src/i2cfs_out_if.sv -----
// ----------------------------------------------------------------------------
// i2cfs_out_if
// Result channel of the sequencer: write words, received bytes, completion.
// ----------------------------------------------------------------------------
interface i2cfs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [9:0] write_word;
  logic [7:0] rx_addr;
  logic [7:0] rx_value;
  logic       done_code;
  logic [7:0] flushed_bytes;
  logic       last;

  modport source (
    output valid, result_kind, write_word, rx_addr, rx_value, done_code,
           flushed_bytes, last,
    input  ready
  );

  modport sink (
    input  valid, result_kind, write_word, rx_addr, rx_value, done_code,
           flushed_bytes, last,
    output ready
  );
endinterface

// ----- src/i2c_fifo_transfer_sequencer.sv -----
// ----------------------------------------------------------------------------
// i2c_fifo_transfer_sequencer
// Drives a byte-FIFO I2C controller through a multi-message transfer held in
// a descriptor table and a byte buffer, both kept in synchronous RAM.
// ----------------------------------------------------------------------------
//  channel  dir  port   carries
//  -------  ---  -----  ------------------------------------------------------
//  input    in   in_i   load descriptor / load byte / start / controller event
//  result   out  out_o  write word / received byte / transfer finished
//
//  Start and event transactions pass through descriptor read, the dependent
//  buffer read, then service with buffer write-back. Results leave the
//  four-entry bank one per cycle while the receiver is ready, and service
//  waits until the bank has drained. A one-entry input register takes the
//  next transaction while the current one is in work.
//  Reset clears control state only; table and buffer contents are kept.
// ----------------------------------------------------------------------------
module i2c_fifo_transfer_sequencer (
  input logic         clk_i,
  input logic         rst_ni,
  i2cfs_in_if.sink    in_i,
  i2cfs_out_if.source out_o
);
  import i2cfs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DESC = 2'd1;
  localparam logic [1:0] ST_SVC  = 2'd2;

  desc_t       desc_mem [MAX_MSGS];
  logic [7:0]  buf_mem  [BUF_DEPTH];

  logic [1:0]        seq_q, seq_d;
  item_t             hold_q;
  logic              hold_vld_q;
  logic              in_acc, take, start_ok, ev_ok, go;

  logic              busy_q;
  logic [MSG_AW-1:0] cur_q;
  logic [REM_W-1:0]  rem_q;
  logic [8:0]        pos_q;
  logic [7:0]        bl_q;
  logic              fp_q;
  logic [7:0]        fc_q;

  logic [9:0]        wk_st_q;
  logic [7:0]        wk_fb_q;
  logic              wk_start_q;

  // RAM ports
  logic              desc_we, desc_re;
  logic [MSG_AW-1:0] desc_wa, desc_ra0, desc_ra1;
  logic [SL_W-1:0]   slot_ext;
  desc_t             desc_wd, dcur_q, dnxt_q;
  logic              buf_we, buf_re, ld_we, svc_we, svc_we_raw;
  logic [BUF_AW-1:0] buf_wa, buf_ra, ld_wa, svc_loc;
  logic [7:0]        buf_wd, bufrd_q;
  logic [SUM_W-1:0]  rd_sum;
  logic [BA_W-1:0]   ba_ext;

  logic [7:0]        nsat;

  // Service results
  logic              fire, bank_free;
  logic              busy_v, fp_v;
  logic [MSG_AW-1:0] cur_v;
  logic [REM_W-1:0]  rem_v;
  logic [8:0]        pos_v;
  logic [7:0]        bl_v, fc_v;
  logic [2:0]        n_v;
  result_t           res_v [RES_N];

  // Result bank
  result_t           res_q [RES_N];
  logic [2:0]        res_cnt_q;
  logic [1:0]        rd_idx_q;
  logic              out_acc, out_last;
  result_t           out_res;

  // --------------------------------------------------------------------------
  // Input register and dispatch
  // --------------------------------------------------------------------------
  assign in_acc   = in_i.valid && in_i.ready;
  assign take     = (seq_q == ST_IDLE) && hold_vld_q;
  assign in_i.ready = !hold_vld_q || take;

  assign start_ok = (hold_q.cmd == CMD_START) && !busy_q && (hold_q.msg_count != 4'd0);
  assign ev_ok    = (hold_q.cmd == CMD_EVENT) && busy_q;
  assign go       = take && (start_ok || ev_ok);

  assign nsat = ({4'd0, hold_q.msg_count} > 8'(MAX_MSGS)) ? 8'(MAX_MSGS)
                                                         : {4'd0, hold_q.msg_count};

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      ST_IDLE: if (go)   seq_d = ST_DESC;
      ST_DESC:           seq_d = ST_SVC;
      ST_SVC:  if (fire) seq_d = ST_IDLE;
      default:           seq_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Descriptor table: one write port, two read ports (current and next entry)
  // --------------------------------------------------------------------------
  function automatic logic [MSG_AW-1:0] nxt_msg(input logic [MSG_AW-1:0] m);
    return (m == MSG_AW'(MAX_MSGS - 1)) ? '0 : m + MSG_AW'(1);
  endfunction

  assign slot_ext = SL_W'(hold_q.desc_slot);
  assign desc_wa  = slot_ext[MSG_AW-1:0];
  assign desc_we  = take && (hold_q.cmd == CMD_LD_DESC)
                    && ({5'd0, hold_q.desc_slot} < 8'(MAX_MSGS));
  assign desc_wd  = '{base: hold_q.msg_base, len: hold_q.msg_length,
                      is_read: hold_q.is_read, addr: hold_q.target_addr};
  assign desc_re  = go;
  assign desc_ra0 = start_ok ? '0 : cur_q;
  assign desc_ra1 = nxt_msg(desc_ra0);

  always_ff @(posedge clk_i) begin
    if (desc_we) desc_mem[desc_wa] <= desc_wd;
    if (desc_re) begin
      dcur_q <= desc_mem[desc_ra0];
      dnxt_q <= desc_mem[desc_ra1];
    end
  end

  // --------------------------------------------------------------------------
  // Byte buffer: loads and received bytes share the write port
  // --------------------------------------------------------------------------
  assign ba_ext = BA_W'(hold_q.byte_addr);
  assign ld_wa  = ba_ext[BUF_AW-1:0];
  assign ld_we  = take && (hold_q.cmd == CMD_LD_BYTE);

  assign rd_sum = SUM_W'(dcur_q.base) + SUM_W'(pos_q[7:0]);
  assign buf_re = (seq_q == ST_DESC);
  assign buf_ra = rd_sum[BUF_AW-1:0];

  assign svc_we = svc_we_raw && fire;
  assign buf_we = ld_we || svc_we;
  assign buf_wa = svc_we ? svc_loc : ld_wa;
  assign buf_wd = svc_we ? wk_fb_q : hold_q.byte_value;

  always_ff @(posedge clk_i) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    if (buf_re) bufrd_q <= buf_mem[buf_ra];
  end

  // --------------------------------------------------------------------------
  // Service: status word against the current descriptor
  // --------------------------------------------------------------------------
  assign bank_free = (res_cnt_q == 3'd0) || (out_acc && out_last);
  assign fire      = (seq_q == ST_SVC) && bank_free;

  always_comb begin : svc_comb
    result_t          e;
    logic             more;
    logic             stop;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] loc_ext;

    busy_v     = busy_q;
    cur_v      = cur_q;
    rem_v      = rem_q;
    pos_v      = pos_q;
    bl_v       = bl_q;
    fp_v       = fp_q;
    fc_v       = fc_q;
    n_v        = 3'd0;
    more       = 1'b1;
    stop       = 1'b0;
    svc_we_raw = 1'b0;
    svc_loc    = '0;
    sum        = '0;
    loc_ext    = '0;
    e          = '0;
    for (int i = 0; i < RES_N; i++) res_v[i] = '0;

    if ((wk_st_q & ST_ERRORS) != 10'd0) begin
      e = '0;
      e.kind = RK_DONE;
      e.done_code = DONE_ERR;
      e.flushed_bytes = fc_v;
      res_v[n_v[1:0]] = e;
      n_v = n_v + 3'd1;
      busy_v = 1'b0;
    end else begin
      // next address or data word
      if ((wk_st_q & ST_WR_FULL) == 10'd0) begin
        if (pos_v == POS_ADDR) begin
          e = '0;
          e.kind = RK_WORD;
          e.write_word = WW_ADDR | {2'b00, dcur_q.addr, dcur_q.is_read};
          if (rem_v == REM_W'(1) && dcur_q.len == 8'd0) e.write_word |= WW_LAST;
          res_v[n_v[1:0]] = e;
          n_v = n_v + 3'd1;
          pos_v = 9'd0;
        end else if (dcur_q.is_read || bl_v == 8'd0) begin
          more = 1'b0;
        end else begin
          e = '0;
          e.kind = RK_WORD;
          e.write_word = {2'b00, bufrd_q};
          if (bl_v == 8'd1 && rem_v == REM_W'(1)) e.write_word |= WW_LAST;
          res_v[n_v[1:0]] = e;
          n_v = n_v + 3'd1;
          pos_v = pos_v + 9'd1;
          bl_v = bl_v - 8'd1;
        end
      end
      // read FIFO byte: store it or flush it
      if ((wk_st_q & ST_RD_FULL) != 10'd0) begin
        if (dcur_q.is_read && pos_v != POS_ADDR && bl_v != 8'd0) begin
          if (bl_v == 8'd2) begin
            stop = 1'b1;
          end else if (bl_v == 8'd1 && pos_v == 9'd0) begin
            fp_v = 1'b1;
            stop = 1'b1;
          end
          if (stop) begin
            e = '0;
            e.kind = RK_WORD;
            e.write_word = WW_LAST;
            res_v[n_v[1:0]] = e;
            n_v = n_v + 3'd1;
          end
          sum        = SUM_W'(dcur_q.base) + SUM_W'(pos_v[7:0]);
          svc_loc    = sum[BUF_AW-1:0];
          svc_we_raw = 1'b1;
          loc_ext    = SUM_W'(svc_loc);
          e = '0;
          e.kind = RK_RX;
          e.rx_addr = loc_ext[7:0];
          e.rx_value = wk_fb_q;
          res_v[n_v[1:0]] = e;
          n_v = n_v + 3'd1;
          bl_v = bl_v - 8'd1;
          pos_v = pos_v + 9'd1;
        end else begin
          if (fc_v[0]) begin
            e = '0;
            e.kind = RK_WORD;
            e.write_word = WW_LAST;
            res_v[n_v[1:0]] = e;
            n_v = n_v + 3'd1;
          end
          if (fp_v) fp_v = 1'b0;
          else if (fc_v != 8'hff) fc_v = fc_v + 8'd1;
        end
      end
      // message complete: move on or finish
      if (pos_v != POS_ADDR && bl_v == 8'd0) begin
        if (rem_v > REM_W'(1)) begin
          rem_v = rem_v - REM_W'(1);
          cur_v = nxt_msg(cur_q);
          pos_v = POS_ADDR;
          bl_v  = dnxt_q.len;
        end else if (!more && !fp_v) begin
          e = '0;
          e.kind = RK_DONE;
          e.done_code = DONE_OK;
          e.flushed_bytes = fc_v;
          res_v[n_v[1:0]] = e;
          n_v = n_v + 3'd1;
          busy_v = 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q      <= ST_IDLE;
      hold_vld_q <= 1'b0;
      busy_q     <= 1'b0;
      cur_q      <= '0;
      rem_q      <= '0;
      pos_q      <= 9'd0;
      bl_q       <= 8'd0;
      fp_q       <= 1'b0;
      fc_q       <= 8'd0;
      res_cnt_q  <= 3'd0;
      rd_idx_q   <= 2'd0;
    end else begin
      seq_q <= seq_d;

      if (in_acc)    hold_vld_q <= 1'b1;
      else if (take) hold_vld_q <= 1'b0;

      if (go && start_ok) begin
        busy_q <= 1'b1;
        cur_q  <= '0;
        rem_q  <= REM_W'(nsat);
        pos_q  <= POS_ADDR;
        fp_q   <= 1'b0;
        fc_q   <= 8'd0;
      end

      // byte count of the first message is latched once its descriptor is in
      if (seq_q == ST_DESC && wk_start_q) bl_q <= dcur_q.len;

      if (fire) begin
        busy_q <= busy_v;
        cur_q  <= cur_v;
        rem_q  <= rem_v;
        pos_q  <= pos_v;
        bl_q   <= bl_v;
        fp_q   <= fp_v;
        fc_q   <= fc_v;
      end

      // a refill replaces the bank as its last result leaves
      if (fire && n_v != 3'd0) begin
        res_cnt_q <= n_v;
        rd_idx_q  <= 2'd0;
      end else if (out_acc) begin
        if (out_last) begin
          res_cnt_q <= 3'd0;
          rd_idx_q  <= 2'd0;
        end else begin
          rd_idx_q  <= rd_idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hold_q.cmd         <= in_i.cmd;
      hold_q.desc_slot   <= in_i.desc_slot;
      hold_q.target_addr <= in_i.target_addr;
      hold_q.is_read     <= in_i.is_read;
      hold_q.msg_length  <= in_i.msg_length;
      hold_q.msg_base    <= in_i.msg_base;
      hold_q.byte_addr   <= in_i.byte_addr;
      hold_q.byte_value  <= in_i.byte_value;
      hold_q.msg_count   <= in_i.msg_count;
      hold_q.status_word <= in_i.status_word;
      hold_q.fifo_byte   <= in_i.fifo_byte;
    end
    if (go) begin
      wk_st_q    <= hold_q.status_word;
      wk_fb_q    <= hold_q.fifo_byte;
      wk_start_q <= start_ok;
    end
    if (fire && n_v != 3'd0) begin
      for (int i = 0; i < RES_N; i++) res_q[i] <= res_v[i];
    end
  end

  // --------------------------------------------------------------------------
  // Result output
  // --------------------------------------------------------------------------
  assign out_res  = res_q[rd_idx_q];
  assign out_last = ({1'b0, rd_idx_q} == (res_cnt_q - 3'd1));
  assign out_acc  = out_o.valid && out_o.ready;

  assign out_o.valid         = (res_cnt_q != 3'd0);
  assign out_o.result_kind   = out_res.kind;
  assign out_o.write_word    = out_res.write_word;
  assign out_o.rx_addr       = out_res.rx_addr;
  assign out_o.rx_value      = out_res.rx_value;
  assign out_o.done_code     = out_res.done_code;
  assign out_o.flushed_bytes = out_res.flushed_bytes;
  assign out_o.last          = out_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // only transactions of a live transfer reach the descriptor and service steps
  a_work_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != ST_IDLE) |-> busy_q)
    else $error("sequencer working without an active transfer");

  a_bank_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (({1'b0, rd_idx_q} < res_cnt_q) && (res_cnt_q <= 3'(RES_N))))
    else $error("result bank index out of range");

  a_buf_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ld_we && svc_we))
    else $error("buffer write port claimed twice");

  // a bank is only refilled after its last result has gone
  a_bank_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && n_v != 3'd0 && res_cnt_q != 3'd0) |-> (out_acc && out_last))
    else $error("result bank overwritten before drained");

endmodule
